[hdl/lmq_pkg.sv]
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared types and codes for the Lamport mutual-exclusion request queues.
// ----------------------------------------------------------------------------
package lmq_pkg;

  localparam int NUM_FILES_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam logic [15:0] CLOCK_TOP = 16'hFFFF;
  localparam logic [3:0]  ACK_TOP   = 4'd15;

  localparam logic [2:0] OP_LOCAL   = 3'd0;
  localparam logic [2:0] OP_REMOTE  = 3'd1;
  localparam logic [2:0] OP_ACK     = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_POLL    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_GRANT  = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  localparam logic [1:0] REG_OWN_ID       = 2'd0;
  localparam logic [1:0] REG_CLIENT_COUNT = 2'd1;
  localparam logic [1:0] REG_FILES_IN_USE = 2'd2;

  typedef struct packed {
    logic [15:0] stamp;
    logic [3:0]  owner;
    logic        kind;
    logic [3:0]  acks;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  file_index;
    logic        access_kind;
    logic [15:0] stamp;
    logic [3:0]  sender_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        grant_valid;
    logic [3:0]  grant_file;
    logic        grant_kind;
    logic [15:0] grant_stamp;
    logic [15:0] clock_value;
  } result_t;

  typedef struct packed {
    logic precedes;
    logic match;
  } cmp_res_t;

endpackage

[hdl/lamport_mutex_request_queue.sv]
// ----------------------------------------------------------------------------
// lamport_mutex_request_queue
// Per-file request queues sorted by (stamp, id) with a Lamport clock.
// ----------------------------------------------------------------------------
//  channel   | signals                          | handshake
//  command   | start, busy, cmd                 | taken when start & !busy
//  result    | done, result                     | one-cycle strobe, no stall
//  config    | psel penable pwrite paddr pwdata | APB, pready always high
//
// A word holds busy while its walk reads the queue and through a closing state,
// S_FIN; a full queue is refused without a walk, and a poll skips empty files
// without reading them. A grant strobes straight from the poll check.
// Reset clears fill counts and the clock; no clearing pass is needed.
// Results cannot be stalled; busy falls in the cycle of the result strobe.
module lamport_mutex_request_queue import lmq_pkg::*; #(
  parameter int NUM_FILES   = NUM_FILES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(NUM_FILES + 1);
  localparam int AW = FW + SW;
  localparam logic [7:0]    NF8     = 8'(NUM_FILES);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_FIN, S_INS_RD, S_INS_CHK, S_FND_RD, S_FND_CHK,
    S_SHF_RD, S_SHF_WR, S_POLL_RD, S_POLL_CHK
  } state_t;

  state_t        state;
  logic [3:0]    own_id;
  logic [3:0]    client_count;
  logic [4:0]    files_in_use;
  logic [15:0]   lamport_clock;
  logic [CW-1:0] fill [NUM_FILES];

  logic [2:0]    op;
  logic [FW-1:0] file;
  logic [15:0]   key_stamp;
  logic [3:0]    key_id;
  logic          key_kind;
  logic [3:0]    key_acks;
  logic [CW-1:0] slot;
  logic [PW-1:0] pidx;
  logic [2:0]    fin_status;

  logic [7:0]    active;
  logic          file_ok;
  logic [15:0]   clock_inc;
  logic [15:0]   clock_abs;
  logic [FW-1:0] cmd_file;
  logic [CW-1:0] slot_m1;
  logic [CW-1:0] slot_p1;
  logic [CW-1:0] cur_fill;
  logic [CW-1:0] poll_fill;
  logic [FW-1:0] pfile;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  entry_t        new_ent;
  cmp_res_t      cmp;
  logic          cfg_wr;

  lmq_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lmq_cmp u_cmp (
    .ent       (mem_rdata),
    .key_stamp (key_stamp),
    .key_id    (key_id),
    .res       (cmp)
  );

  assign busy     = (state != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign active   = ({3'b000, files_in_use} > NF8) ? NF8 : {3'b000, files_in_use};
  assign file_ok  = ({4'b0000, cmd.file_index} < active);
  assign cmd_file = FW'(cmd.file_index);
  assign clock_inc = (lamport_clock == CLOCK_TOP) ? lamport_clock : lamport_clock + 16'd1;
  assign clock_abs = (cmd.stamp > lamport_clock) ? cmd.stamp : lamport_clock;
  assign slot_m1  = slot - CW'(1);
  assign slot_p1  = slot + CW'(1);
  assign cur_fill = fill[file];
  assign pfile    = pidx[FW-1:0];
  assign poll_fill = fill[pfile];

  assign new_ent.stamp = key_stamp;
  assign new_ent.owner = key_id;
  assign new_ent.kind  = key_kind;
  assign new_ent.acks  = key_acks;

  always_comb begin
    case (paddr[3:2])
      REG_OWN_ID:       prdata = {28'd0, own_id};
      REG_CLIENT_COUNT: prdata = {28'd0, client_count};
      REG_FILES_IN_USE: prdata = {27'd0, files_in_use};
      default:          prdata = 32'd0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {file, slot[SW-1:0]};
    mem_wdata = new_ent;
    mem_raddr = {file, slot[SW-1:0]};
    case (state)
      S_INS_RD: begin
        if (slot == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_raddr = {file, slot_m1[SW-1:0]};
        end
      end
      S_INS_CHK: begin
        mem_we = 1'b1;
        if (!cmp.precedes) begin
          mem_wdata = mem_rdata;
        end
      end
      S_FND_CHK: begin
        mem_wdata      = mem_rdata;
        mem_wdata.acks = (mem_rdata.acks == ACK_TOP) ? ACK_TOP : mem_rdata.acks + 4'd1;
        mem_we         = cmp.match && (op == OP_ACK);
      end
      S_SHF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {file, slot_m1[SW-1:0]};
        mem_wdata = mem_rdata;
      end
      S_POLL_RD: begin
        mem_raddr = {pfile, {SW{1'b0}}};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      own_id        <= 4'd1;
      client_count  <= 4'd5;
      files_in_use  <= 5'd16;
      lamport_clock <= 16'd0;
      done          <= 1'b0;
      for (int i = 0; i < NUM_FILES; i++) begin
        fill[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_OWN_ID:       own_id       <= pwdata[3:0];
          REG_CLIENT_COUNT: client_count <= pwdata[3:0];
          REG_FILES_IN_USE: files_in_use <= pwdata[4:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            op         <= cmd.operation;
            file       <= cmd_file;
            key_stamp  <= cmd.stamp;
            key_id     <= cmd.sender_id;
            key_kind   <= cmd.access_kind;
            key_acks   <= 4'd0;
            slot       <= fill[cmd_file];
            pidx       <= '0;
            fin_status <= ST_IGNORED;
            state      <= S_FIN;
            case (cmd.operation)
              OP_LOCAL: begin
                if (file_ok) begin
                  lamport_clock <= clock_inc;
                  key_stamp     <= clock_inc;
                  key_id        <= own_id;
                  key_acks      <= 4'd1;
                  state         <= S_INS_RD;
                end
              end
              OP_REMOTE: begin
                lamport_clock <= clock_abs;
                if (file_ok && (cmd.sender_id != own_id)) begin
                  state <= S_INS_RD;
                end
              end
              OP_ACK, OP_RELEASE: begin
                lamport_clock <= clock_abs;
                slot          <= '0;
                if (file_ok) begin
                  state <= S_FND_RD;
                end
              end
              OP_POLL: begin
                state <= S_POLL_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_FIN: begin
          done                 <= 1'b1;
          result.status        <= fin_status;
          result.grant_valid   <= 1'b0;
          result.grant_file    <= 4'd0;
          result.grant_kind    <= 1'b0;
          result.grant_stamp   <= 16'd0;
          result.clock_value   <= lamport_clock;
          state                <= S_IDLE;
        end
        S_INS_RD: begin
          if (cur_fill == DEPTH_C) begin
            fin_status <= ST_FULL;
            state      <= S_FIN;
          end else if (slot == '0) begin
            fill[file] <= cur_fill + CW'(1);
            fin_status <= ST_OK;
            state      <= S_FIN;
          end else begin
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          // The new entry lands behind the last entry that sorts before it, found walking back from the tail.
          if (cmp.precedes) begin
            fill[file] <= cur_fill + CW'(1);
            fin_status <= ST_OK;
            state      <= S_FIN;
          end else begin
            slot  <= slot_m1;
            state <= S_INS_RD;
          end
        end
        S_FND_RD: begin
          if (slot == cur_fill) begin
            fin_status <= ST_NOT_FOUND;
            state      <= S_FIN;
          end else begin
            state <= S_FND_CHK;
          end
        end
        S_FND_CHK: begin
          if (cmp.match) begin
            if (op == OP_ACK) begin
              fin_status <= ST_OK;
              state      <= S_FIN;
            end else begin
              slot  <= slot_p1;
              state <= S_SHF_RD;
            end
          end else begin
            slot  <= slot_p1;
            state <= S_FND_RD;
          end
        end
        S_SHF_RD: begin
          if (slot == cur_fill) begin
            fill[file] <= cur_fill - CW'(1);
            fin_status <= ST_OK;
            state      <= S_FIN;
          end else begin
            state <= S_SHF_WR;
          end
        end
        S_SHF_WR: begin
          slot  <= slot_p1;
          state <= S_SHF_RD;
        end
        S_POLL_RD: begin
          if (8'(pidx) == active) begin
            fin_status <= ST_NO_GRANT;
            state      <= S_FIN;
          end else if (poll_fill == '0) begin
            pidx <= pidx + PW'(1);
          end else begin
            state <= S_POLL_CHK;
          end
        end
        S_POLL_CHK: begin
          if ((mem_rdata.owner == own_id) && (mem_rdata.acks == client_count)) begin
            done               <= 1'b1;
            result.status      <= ST_OK;
            result.grant_valid <= 1'b1;
            result.grant_file  <= 4'(pidx);
            result.grant_kind  <= mem_rdata.kind;
            result.grant_stamp <= mem_rdata.stamp;
            result.clock_value <= lamport_clock;
            state              <= S_IDLE;
          end else begin
            pidx  <= pidx + PW'(1);
            state <= S_POLL_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a word in flight");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.grant_valid) |-> (result.status == ST_OK))
    else $error("grant reported with a non-ok status");

endmodule

[hdl/lmq_store.sv]
// ----------------------------------------------------------------------------
// lmq_store
// Entry memory for all queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lmq_store import lmq_pkg::*; #(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/lmq_cmp.sv]
// ----------------------------------------------------------------------------
// lmq_cmp
// Key compare unit shared by insert and lookup walks.
// ----------------------------------------------------------------------------
module lmq_cmp import lmq_pkg::*; (
  input  entry_t      ent,
  input  logic [15:0] key_stamp,
  input  logic [3:0]  key_id,
  output cmp_res_t    res
);

  logic same_stamp;

  assign same_stamp = (ent.stamp == key_stamp);
  // An entry sorts before the key on a smaller stamp, then a smaller id.
  assign res.precedes = (ent.stamp < key_stamp) || (same_stamp && (ent.owner < key_id));
  assign res.match    = same_stamp && (ent.owner == key_id);

endmodule

[tb/lamport_mutex_request_queue_tb.sv]
// ----------------------------------------------------------------------------
// lamport_mutex_request_queue_tb
// Drives request, acknowledgment, release and poll words into the request
// queue block, predicts every result word with a behavioral model of the
// sorted queues and the Lamport clock, and compares them field by field.
// ----------------------------------------------------------------------------
module lamport_mutex_request_queue_tb;
  import lmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = NUM_FILES_DEF;
  localparam int QD = QUEUE_DEPTH_DEF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lamport_mutex_request_queue u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [3:0]  m_own = 4'd1;
  logic [3:0]  m_count = 4'd5;
  logic [4:0]  m_files = 5'd16;
  entry_t      m_q[NF][QD];
  int          m_fill[NF];
  logic [15:0] m_clock = '0;

  cmd_t    pending_cmds[$];
  result_t expected_results[$];
  int      errors = 0;
  bit      idle_off = 1'b0;
  int      send_gap = 0;

  function automatic result_t predict_result(cmd_t c);
    result_t r;
    int active, n, pos, idx;
    bit file_ok;
    r = '0;
    r.status = ST_IGNORED;
    active = (m_files > NF) ? NF : m_files;
    file_ok = c.file_index < active;
    if (c.operation != OP_LOCAL && c.operation <= OP_RELEASE && c.stamp > m_clock)
      m_clock = c.stamp;
    case (c.operation)
      OP_LOCAL, OP_REMOTE: begin
        if (file_ok && (c.operation == OP_LOCAL || c.sender_id != m_own)) begin
          entry_t e;
          if (c.operation == OP_LOCAL) begin
            if (m_clock != CLOCK_TOP) m_clock++;
            e.stamp = m_clock; e.owner = m_own; e.acks = 4'd1;
          end else begin
            e.stamp = c.stamp; e.owner = c.sender_id; e.acks = 4'd0;
          end
          e.kind = c.access_kind;
          n = m_fill[c.file_index];
          if (n >= QD) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < n && (m_q[c.file_index][pos].stamp < e.stamp ||
                   (m_q[c.file_index][pos].stamp == e.stamp &&
                    m_q[c.file_index][pos].owner < e.owner)))
              pos++;
            for (int i = n; i > pos; i--) m_q[c.file_index][i] = m_q[c.file_index][i-1];
            m_q[c.file_index][pos] = e;
            m_fill[c.file_index] = n + 1;
            r.status = ST_OK;
          end
        end
      end
      OP_ACK, OP_RELEASE: begin
        if (file_ok) begin
          n = m_fill[c.file_index];
          idx = -1;
          for (int i = 0; i < n; i++)
            if (idx < 0 && m_q[c.file_index][i].stamp == c.stamp &&
                m_q[c.file_index][i].owner == c.sender_id) idx = i;
          if (idx < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.status = ST_OK;
            if (c.operation == OP_ACK) begin
              if (m_q[c.file_index][idx].acks != ACK_TOP) m_q[c.file_index][idx].acks++;
            end else begin
              for (int i = idx; i < n - 1; i++) m_q[c.file_index][i] = m_q[c.file_index][i+1];
              m_fill[c.file_index] = n - 1;
            end
          end
        end
      end
      OP_POLL: begin
        r.status = ST_NO_GRANT;
        for (int i = 0; i < active; i++)
          if (!r.grant_valid && m_fill[i] != 0 && m_q[i][0].owner == m_own &&
              m_q[i][0].acks == m_count) begin
            r.status = ST_OK;
            r.grant_valid = 1'b1;
            r.grant_file = i[3:0];
            r.grant_kind = m_q[i][0].kind;
            r.grant_stamp = m_q[i][0].stamp;
          end
      end
      default: ;
    endcase
    r.clock_value = m_clock;
    return r;
  endfunction

  // Driver: a word is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(predict_result(cmd));
        void'(pending_cmds.pop_front());
        if (!idle_off && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
      end
      if (start && busy) begin
        // Hold the word until it is taken.
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        start <= 1'b1;
        cmd <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    result_t x;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", result);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (result.status !== x.status) begin
          $error("status exp %0d got %0d", x.status, result.status); errors++;
        end
        if (result.grant_valid !== x.grant_valid) begin
          $error("grant_valid exp %0d got %0d", x.grant_valid, result.grant_valid); errors++;
        end
        if (result.grant_file !== x.grant_file) begin
          $error("grant_file exp %0d got %0d", x.grant_file, result.grant_file); errors++;
        end
        if (result.grant_kind !== x.grant_kind) begin
          $error("grant_kind exp %0d got %0d", x.grant_kind, result.grant_kind); errors++;
        end
        if (result.grant_stamp !== x.grant_stamp) begin
          $error("grant_stamp exp %0d got %0d", x.grant_stamp, result.grant_stamp); errors++;
        end
        if (result.clock_value !== x.clock_value) begin
          $error("clock_value exp %0d got %0d", x.clock_value, result.clock_value); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OWN_ID:       m_own = val[3:0];
      REG_CLIENT_COUNT: m_count = val[3:0];
      default:          m_files = val[4:0];
    endcase
  endtask

  function automatic cmd_t mk(logic [2:0] op, int f, bit k, int s, int id);
    cmd_t c;
    c.operation = op; c.file_index = f[3:0]; c.access_kind = k;
    c.stamp = s[15:0]; c.sender_id = id[3:0];
    return c;
  endfunction

  // Mostly well-formed traffic on the first nfiles files with stamps near the clock.
  task automatic add_random(int num, int nfiles);
    cmd_t c;
    int r, f;
    for (int i = 0; i < num; i++) begin
      r = $urandom_range(0, 99);
      f = $urandom_range(0, nfiles - 1);
      if (r < 4) begin
        c = 28'($urandom);
      end else begin
        c = mk(OP_REMOTE, f, $urandom_range(0, 1),
               m_clock + $urandom_range(0, 6), $urandom_range(1, 8));
        if (r < 20) c.operation = OP_LOCAL;
        else if (r < 40) c.operation = OP_REMOTE;
        else if (r < 70) c.operation = OP_ACK;
        else if (r < 85) c.operation = OP_RELEASE;
        else c.operation = OP_POLL;
        if ((c.operation == OP_ACK || c.operation == OP_RELEASE) && m_fill[f] > 0 &&
            $urandom_range(0, 3) != 0) begin
          int e;
          e = $urandom_range(0, m_fill[f] - 1);
          c.stamp = m_q[f][e].stamp;
          c.sender_id = m_q[f][e].owner;
        end
      end
      pending_cmds.push_back(c);
      // Keep the model in step so that matching stamps are drawn from live entries.
      while (pending_cmds.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // Directed part.
    pending_cmds.push_back(mk(OP_POLL, 0, 0, 0, 1));
    pending_cmds.push_back(mk(OP_LOCAL, 0, 1, 0, 1));
    pending_cmds.push_back(mk(OP_REMOTE, 0, 0, 1, 2));
    pending_cmds.push_back(mk(OP_REMOTE, 0, 0, 1, 1));
    pending_cmds.push_back(mk(OP_REMOTE, 0, 1, 1, 0));
    pending_cmds.push_back(mk(OP_ACK, 0, 0, 1, 1));
    pending_cmds.push_back(mk(OP_ACK, 0, 0, 9, 1));
    pending_cmds.push_back(mk(OP_RELEASE, 0, 0, 7, 3));
    for (int i = 0; i < 3; i++) pending_cmds.push_back(mk(OP_ACK, 0, 0, 1, 1));
    pending_cmds.push_back(mk(OP_POLL, 0, 0, 0, 1));
    pending_cmds.push_back(mk(OP_RELEASE, 0, 0, 1, 0));
    pending_cmds.push_back(mk(3'd5, 15, 1, 65535, 15));
    pending_cmds.push_back(mk(3'd7, 15, 1, 65535, 15));
    for (int i = 0; i < 9; i++) pending_cmds.push_back(mk(OP_REMOTE, 15, 1, 65535, 8));
    pending_cmds.push_back(mk(OP_LOCAL, 15, 0, 0, 1));
    pending_cmds.push_back(mk(OP_LOCAL, 14, 0, 0, 1));
    wait_drained();
    for (int i = 0; i < 20; i++) pending_cmds.push_back(mk(OP_ACK, 14, 0, 65535, 1));
    pending_cmds.push_back(mk(OP_POLL, 0, 0, 0, 1));
    wait_drained();
    // Fresh clock values are not reachable again; settle with saturated clock.
    write_reg(REG_FILES_IN_USE, 32'd0);
    pending_cmds.push_back(mk(OP_LOCAL, 0, 0, 0, 1));
    pending_cmds.push_back(mk(OP_POLL, 0, 0, 0, 1));
    wait_drained();
    write_reg(REG_OWN_ID, 32'd8);
    write_reg(REG_CLIENT_COUNT, 32'd1);
    write_reg(REG_FILES_IN_USE, 32'd31);
    add_random(300, 16);
    wait_drained();
    write_reg(REG_OWN_ID, 32'd1);
    write_reg(REG_CLIENT_COUNT, 32'd8);
    write_reg(REG_FILES_IN_USE, 32'd1);
    add_random(300, 4);
    wait_drained();
    write_reg(REG_OWN_ID, 32'd3);
    write_reg(REG_CLIENT_COUNT, 32'd2);
    write_reg(REG_FILES_IN_USE, 32'd3);
    add_random(500, 5);
    wait_drained();
    write_reg(REG_OWN_ID, 32'd5);
    write_reg(REG_CLIENT_COUNT, 32'd3);
    write_reg(REG_FILES_IN_USE, 32'd16);
    add_random(450, 16);
    idle_off = 1'b1;
    add_random(400, 2);
    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
